/* rtl/cc2p_pkg.sv */
// ============================================================================
// cc2p_pkg
// Shared constants, types and the arctangent table for the CORDIC
// Cartesian-to-polar pipeline.
// ============================================================================
package cc2p_pkg;

    // micro-rotation count and table size
    localparam int ITERATIONS   = 16;
    localparam int ATAN_ENTRIES = 20;
    localparam int NUM_ROT      = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;
    localparam int IDX_W        = $clog2(ATAN_ENTRIES);

    // field and datapath widths
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int EXTRA_BITS = 16;
    localparam int DW         = 36;   // x/y datapath, 30 fractional bits
    localparam int AW         = 34;   // angle accumulator, 30 fractional bits

    // gain correction split multiply
    localparam int GAIN_W = 30;
    localparam int MAG_W  = 34;       // positive final x fits in this many bits
    localparam int LO_W   = 17;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = LO_W + GAIN_W;
    localparam int PHI_W  = HI_W + GAIN_W;
    localparam int PW     = 64;
    localparam int RAD_SHIFT = 46;
    localparam int ANG_SHIFT = 17;

    localparam logic [GAIN_W-1:0]    GAIN_Q30     = 30'd652032874;
    localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1686629713;

    // one word in flight between rotation stages
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] acc;
    } cc2p_vec_t;

    // round(atan(2^-i) * 2^30)
    function automatic logic signed [AW-1:0] atan_q30(input logic [IDX_W-1:0] idx);
        logic signed [AW-1:0] v;
        begin
            case (idx)
                5'd0:    v = 34'sd843314857;
                5'd1:    v = 34'sd497837829;
                5'd2:    v = 34'sd263043837;
                5'd3:    v = 34'sd133525159;
                5'd4:    v = 34'sd67021687;
                5'd5:    v = 34'sd33543516;
                5'd6:    v = 34'sd16775851;
                5'd7:    v = 34'sd8388437;
                5'd8:    v = 34'sd4194283;
                5'd9:    v = 34'sd2097149;
                5'd10:   v = 34'sd1048576;
                5'd11:   v = 34'sd524288;
                5'd12:   v = 34'sd262144;
                5'd13:   v = 34'sd131072;
                5'd14:   v = 34'sd65536;
                5'd15:   v = 34'sd32768;
                5'd16:   v = 34'sd16384;
                5'd17:   v = 34'sd8192;
                5'd18:   v = 34'sd4096;
                5'd19:   v = 34'sd2048;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/cc2p_in_if.sv */
// ============================================================================
// cc2p_in_if
// Input channel: one Cartesian point per word, valid/ready handshake.
// ============================================================================
interface cc2p_in_if;
    import cc2p_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] coord_x;
    logic signed [IN_W-1:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

/* rtl/cc2p_out_if.sv */
// ============================================================================
// cc2p_out_if
// Output channel: one polar result per word, valid/ready handshake.
// ============================================================================
interface cc2p_out_if;
    import cc2p_pkg::*;

    logic                    valid;
    logic                    ready;
    logic        [OUT_W-1:0] radius;
    logic signed [OUT_W-1:0] angle;

    modport source (output valid, output radius, output angle, input ready);
    modport sink   (input valid, input radius, input angle, output ready);
endinterface

/* rtl/cc2p_prerot.sv */
// ============================================================================
// cc2p_prerot
// Quarter-turn pre-rotation: turns the point toward positive x, scales it
// into the wide datapath and seeds the angle with plus or minus pi/2.
// ============================================================================
module cc2p_prerot (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [cc2p_pkg::IN_W-1:0] coord_x,
    input  logic signed [cc2p_pkg::IN_W-1:0] coord_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cc2p_pkg::cc2p_vec_t             out_vec
);
    import cc2p_pkg::*;

    logic                 valid_reg;
    cc2p_vec_t            vec_reg;
    cc2p_vec_t            vec_next;
    logic signed [DW-1:0] xe;
    logic signed [DW-1:0] ye;

    // widen and scale by 2^16
    assign xe = DW'(coord_x) <<< EXTRA_BITS;
    assign ye = DW'(coord_y) <<< EXTRA_BITS;

    // zero y counts as negative
    always_comb
    begin
        if (coord_y > 0)
        begin
            vec_next.x   = ye;
            vec_next.y   = -xe;
            vec_next.acc = QUARTER_TURN;
        end
        else
        begin
            vec_next.x   = -ye;
            vec_next.y   = xe;
            vec_next.acc = -QUARTER_TURN;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

`ifndef SYNTHESIS
    // seed angle is always a quarter turn one way or the other
    a_seed: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg &&
            (vec_reg.acc == QUARTER_TURN || vec_reg.acc == -QUARTER_TURN))
        else $error("pre-rotation seed angle wrong");

    // pre-rotated x never negative
    a_xpos: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !vec_reg.x[DW-1])
        else $error("pre-rotated x is negative");
`endif

endmodule

/* rtl/cc2p_micro.sv */
// ============================================================================
// cc2p_micro
// One CORDIC vectoring micro-rotation with its pipeline register; the
// shift index is tied to a constant by the instantiating level.
// ============================================================================
module cc2p_micro (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cc2p_pkg::IDX_W-1:0]  idx,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cc2p_pkg::cc2p_vec_t         in_vec,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cc2p_pkg::cc2p_vec_t         out_vec
);
    import cc2p_pkg::*;

    logic                 valid_reg;
    cc2p_vec_t            vec_reg;
    cc2p_vec_t            vec_next;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic signed [AW-1:0] step;
    logic                 y_pos;

    assign xs    = in_vec.y >>> idx;
    assign ys    = in_vec.x >>> idx;
    assign step  = atan_q30(idx);
    assign y_pos = !in_vec.y[DW-1] && (in_vec.y != '0);

    // direction from the sign of y, zero counts as negative
    always_comb
    begin
        if (y_pos)
        begin
            vec_next.x   = in_vec.x + xs;
            vec_next.y   = in_vec.y - ys;
            vec_next.acc = in_vec.acc + step;
        end
        else
        begin
            vec_next.x   = in_vec.x - xs;
            vec_next.y   = in_vec.y + ys;
            vec_next.acc = in_vec.acc - step;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

`ifndef SYNTHESIS
    // a stalled stage keeps its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(vec_reg))
        else $error("rotation stage lost its word under stall");
`endif

endmodule

/* rtl/cc2p_gain.sv */
// ============================================================================
// cc2p_gain
// Gain correction and output rounding: the final x is multiplied by the
// CORDIC gain in two partial products, then summed, rounded and saturated.
// ============================================================================
module cc2p_gain (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  cc2p_pkg::cc2p_vec_t              in_vec,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic        [cc2p_pkg::OUT_W-1:0] radius,
    output logic signed [cc2p_pkg::OUT_W-1:0] angle
);
    import cc2p_pkg::*;

    localparam logic [PW-1:0]   RAD_ROUND = PW'(1) << (RAD_SHIFT - 1);
    localparam logic [AW:0]     ANG_ROUND = (AW + 1)'(1) << (ANG_SHIFT - 1);
    localparam int              AQ_W      = AW + 1 - ANG_SHIFT;
    localparam int              RQ_W      = PW - RAD_SHIFT;

    // partial product stage
    logic                 va_reg;
    logic                 pos_reg;
    logic [PLO_W-1:0]     plo_reg;
    logic [PHI_W-1:0]     phi_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 ready_a;
    logic                 pos_next;
    logic [LO_W-1:0]      x_lo;
    logic [HI_W-1:0]      x_hi;

    // rounding stage
    logic                    vb_reg;
    logic [OUT_W-1:0]        radius_reg;
    logic signed [OUT_W-1:0] angle_reg;
    logic [OUT_W-1:0]        radius_next;
    logic signed [OUT_W-1:0] angle_next;
    logic [PW-1:0]           prod;
    logic [RQ_W-1:0]         rad_q;
    logic signed [AW:0]      acc_r;
    logic signed [AQ_W-1:0]  ang_q;

    assign pos_next = !in_vec.x[DW-1] && (in_vec.x != '0);
    assign x_lo     = in_vec.x[LO_W-1:0];
    assign x_hi     = in_vec.x[MAG_W-1:LO_W];

    assign in_ready = !va_reg || ready_a;
    assign ready_a  = !vb_reg || out_ready;

    // full product, rounded half up to Q2.14
    assign prod  = (PW'(phi_reg) << LO_W) + PW'(plo_reg) + RAD_ROUND;
    assign rad_q = prod[PW-1:RAD_SHIFT];

    always_comb
    begin
        if (!pos_reg)
            radius_next = '0;
        else if (rad_q > RQ_W'({OUT_W{1'b1}}))
            radius_next = '1;
        else
            radius_next = rad_q[OUT_W-1:0];
    end

    // angle rounded half up to Q3.13, then saturated
    assign acc_r = (AW + 1)'(acc_reg) + signed'(ANG_ROUND);
    assign ang_q = acc_r[AW:ANG_SHIFT];

    always_comb
    begin
        if (ang_q > AQ_W'(signed'({1'b0, {(OUT_W-1){1'b1}}})))
            angle_next = {1'b0, {(OUT_W-1){1'b1}}};
        else if (ang_q < AQ_W'(signed'({1'b1, {(OUT_W-1){1'b0}}})))
            angle_next = {1'b1, {(OUT_W-1){1'b0}}};
        else
            angle_next = ang_q[OUT_W-1:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                va_reg <= in_valid;
            if (ready_a)
                vb_reg <= va_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            pos_reg <= pos_next;
            plo_reg <= PLO_W'(x_lo) * PLO_W'(GAIN_Q30);
            phi_reg <= PHI_W'(x_hi) * PHI_W'(GAIN_Q30);
            acc_reg <= in_vec.acc;
        end
        if (ready_a)
        begin
            radius_reg <= radius_next;
            angle_reg  <= angle_next;
        end
    end

    assign out_valid = vb_reg;
    assign radius    = radius_reg;
    assign angle     = angle_reg;

`ifndef SYNTHESIS
    // a word in the product stage reaches the output register when it moves
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg && ready_a |=> vb_reg)
        else $error("word dropped between product and rounding stage");

    // non-positive x always gives zero radius
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg && !pos_reg && ready_a |=> radius_reg == '0)
        else $error("non-positive x gave nonzero radius");
`endif

endmodule

/* rtl/cordic_cart_to_polar_top.sv */
// ============================================================================
// cordic_cart_to_polar_top
// CORDIC vectoring Cartesian-to-polar converter, fully pipelined.
// ============================================================================
// Takes one (coord_x, coord_y) word per cycle, Q2.14 signed, and returns
// radius (unsigned Q2.14, gain corrected) and angle (signed Q3.13 radians)
// one word per cycle while the output is ready. The default has 16
// micro-rotations: one register for the quarter-turn pre-rotation, one per
// micro-rotation, and two in the gain stage, where the 34-bit x times the
// 30-bit gain is formed as two partial products and then summed and rounded.
// Every stage holds its word under output back-pressure, and empty stages
// keep filling while the output waits, so a stall loses nothing.
module cordic_cart_to_polar_top (
    input  logic      clk,
    input  logic      rst_n,
    cc2p_in_if.sink   cart,
    cc2p_out_if.source polar
);
    import cc2p_pkg::*;

    logic      valid_s [NUM_ROT+1];
    logic      ready_s [NUM_ROT+1];
    cc2p_vec_t vec_s   [NUM_ROT+1];

    // quarter-turn pre-rotation
    cc2p_prerot u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cart.valid),
        .in_ready  (cart.ready),
        .coord_x   (cart.coord_x),
        .coord_y   (cart.coord_y),
        .out_valid (valid_s[0]),
        .out_ready (ready_s[0]),
        .out_vec   (vec_s[0])
    );

    // micro-rotation chain
    for (genvar k = 0; k < NUM_ROT; k++)
    begin : g_rot
        cc2p_micro u_micro (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IDX_W'(k)),
            .in_valid  (valid_s[k]),
            .in_ready  (ready_s[k]),
            .in_vec    (vec_s[k]),
            .out_valid (valid_s[k+1]),
            .out_ready (ready_s[k+1]),
            .out_vec   (vec_s[k+1])
        );
    end

    // gain correction and output rounding
    cc2p_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_s[NUM_ROT]),
        .in_ready  (ready_s[NUM_ROT]),
        .in_vec    (vec_s[NUM_ROT]),
        .out_valid (polar.valid),
        .out_ready (polar.ready),
        .radius    (polar.radius),
        .angle     (polar.angle)
    );

endmodule
